// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the oscillator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CHK_ALWAYS(lbl, cond, msg)
`define CHK_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/wmo_pkg.sv =====
// Types and constants of the wavetable mix oscillator.
package wmo_pkg;

  // Phase fraction bits and weight format (Q2.14)
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 14;
  localparam int PROD_SHIFT  = FRAC_BITS + WEIGHT_FRAC;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int PHASE_INC_W = 24;
  localparam int TIU_W       = 3;
  localparam int NUM_WEIGHT_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO = 3'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO_RESET = 16'd16384;
  localparam logic [TIU_W-1:0]    TABLES_RESET      = 3'd1;

  // Input commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/wmo_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module wmo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/wavetable_mix_oscillator_top.sv =====
// Top level of the wavetable mix oscillator with linear interpolation.
// Wavetable oscillator. A write transaction (command 0) stores one signed sample
// into table table_select at entry_index and leaves the block idle; writes
// to a table or entry beyond the configured size are dropped. A sample
// transaction (command 1) reads every active table at the current phase, blends
// the entry below the phase with the next one (wrapping at the table end), scales
// each blend by its Q2.14 weight, sums exactly, rounds half up and saturates to
// SAMPLE_BITS. All tables share one memory with two read ports, so one table (both
// neighbouring entries) is read per cycle. While the tables are read, the phase
// wrap is reduced in 26-PHASE_W steps for short tables and in one step for tables
// of 512 entries and more; the run ends once both are done and every product is
// summed. The block then enters its finish state, loads the result when the output
// register is free or being read, and returns to idle as it does so. One sample
// is worked on at a time. The result register parts the output side from the
// input: a new transaction is taken while a result still waits. Weights exist
// for tables zero to three only; further tables mix with weight zero. Write
// configuration only while the block is idle. Table entries are undefined until
// written and have no clearing pass.
`include "assert_macros.svh"
module wavetable_mix_oscillator_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int NUM_TABLES  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [wmo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmo_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [1:0]                         table_select,
  input  logic [7:0]                         entry_index,
  input  logic signed [SAMPLE_BITS-1:0]      entry_value,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam int FB      = wmo_pkg::FRAC_BITS;
  localparam int IW      = $clog2(TABLE_DEPTH);
  localparam int PHASE_W = IW + FB;
  localparam int TW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW      = TW + IW;
  localparam int CNT_W   = $clog2(NUM_TABLES + 1);
  localparam int CMP_W   = (CNT_W > wmo_pkg::TIU_W) ? CNT_W : wmo_pkg::TIU_W;
  localparam int NW      = (NUM_TABLES < wmo_pkg::NUM_WEIGHT_REGS) ?
                           NUM_TABLES : wmo_pkg::NUM_WEIGHT_REGS;
  // Phase plus increment stays below span << (RED_K + 1)
  localparam int SUM_W   = ((PHASE_W > 25) ? PHASE_W : 25) + 1;
  localparam int RED_K   = (PHASE_W >= 25) ? 0 : 25 - PHASE_W;
  localparam int RL_W    = $clog2(RED_K + 2);
  localparam int IP_W    = SAMPLE_BITS + FB;
  localparam int MUL_W   = SAMPLE_BITS + FB + 2;
  localparam int PROD_W  = IP_W + wmo_pkg::WEIGHT_W;
  localparam int ACC_W   = PROD_W + 4;
  localparam int SAT_HI_I = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAT_LO_I = -(2 ** (SAMPLE_BITS - 1));
  localparam logic [SUM_W-1:0] SPAN = SUM_W'(TABLE_DEPTH) << FB;

  // Configuration registers
  logic [wmo_pkg::PHASE_INC_W-1:0]   phase_inc;
  logic [wmo_pkg::TIU_W-1:0]         tables_in_use;
  logic signed [wmo_pkg::WEIGHT_W-1:0] weight [NW];

  // Control
  wmo_pkg::state_t state, state_next;
  logic [SUM_W-1:0]   phase;
  logic [RL_W-1:0]    red_left;
  logic [RL_W-1:0]    red_sh;
  logic [SUM_W-1:0]   red_lim;
  logic [CNT_W-1:0]   act;
  logic [CNT_W-1:0]   iss;
  logic               v_rd, v_ip, v_pr;
  logic [TW-1:0]      tbl_rd, tbl_ip;
  logic               run_done;

  // Payload of the sample in flight
  logic [IW-1:0]      below_idx, above_idx;
  logic [FB-1:0]      frac;
  logic [IW-1:0]      cur_below, cur_above;

  // Datapath
  logic [SAMPLE_BITS-1:0]      rd_a, rd_b;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [MUL_W-1:0]     mul, base, ip_full;
  logic signed [IP_W-1:0]      interp;
  logic signed [wmo_pkg::WEIGHT_W-1:0] w_sel;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W:0]       rsum, rq;
  logic signed [SAMPLE_BITS-1:0] sat;

  // Memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, raddr_a, raddr_b;
  logic [CMP_W-1:0]   tiu_ext;

  logic in_acc;
  assign in_ready = (state == wmo_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Table writes go straight into the memory on acceptance
  assign mem_we    = in_acc && (command == wmo_pkg::CMD_WRITE) &&
                     (int'(table_select) < NUM_TABLES) && (int'(entry_index) < TABLE_DEPTH);
  assign mem_waddr = {TW'(table_select), IW'(entry_index)};
  assign raddr_a   = {iss[TW-1:0], below_idx};
  assign raddr_b   = {iss[TW-1:0], above_idx};

  wmo_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (2 ** AW)
  ) u_table_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (entry_value),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc     <= '0;
      tables_in_use <= wmo_pkg::TABLES_RESET;
      for (int i = 0; i < NW; i++) begin
        weight[i] <= (i == 0) ? wmo_pkg::WEIGHT_ZERO_RESET : '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == wmo_pkg::REG_PHASE_INC) begin
        phase_inc <= cfg_data[wmo_pkg::PHASE_INC_W-1:0];
      end
      if (cfg_index == wmo_pkg::REG_TABLES) begin
        tables_in_use <= cfg_data[wmo_pkg::TIU_W-1:0];
      end
      for (int i = 0; i < NW; i++) begin
        if (cfg_index == (wmo_pkg::REG_WEIGHT_ZERO + wmo_pkg::CFG_IDX_W'(i))) begin
          weight[i] <= cfg_data[wmo_pkg::WEIGHT_W-1:0];
        end
      end
    end
  end

  // Phase of the current sample: entry below and its wrapped neighbour
  assign cur_below = phase[PHASE_W-1:FB];
  assign cur_above = (cur_below == IW'(TABLE_DEPTH - 1)) ? '0 : cur_below + IW'(1);
  assign tiu_ext   = CMP_W'(tables_in_use);

  // Wrap reduction: subtract span << k for k from RED_K down to zero
  assign red_sh  = red_left - RL_W'(1);
  assign red_lim = SPAN << red_sh;

  // Interpolation: a*65536 + (b-a)*f
  always_comb begin
    diff    = $signed({rd_b[SAMPLE_BITS-1], rd_b}) - $signed({rd_a[SAMPLE_BITS-1], rd_a});
    mul     = MUL_W'(diff) * MUL_W'($signed({1'b0, frac}));
    base    = $signed({{2{rd_a[SAMPLE_BITS-1]}}, rd_a, {FB{1'b0}}});
    ip_full = base + mul;
  end

  // Weight of the table in the interpolation register; absent weights are zero
  always_comb begin
    w_sel = '0;
    for (int i = 0; i < NW; i++) begin
      if (tbl_ip == TW'(i)) begin
        w_sel = weight[i];
      end
    end
  end

  // Round half up, then saturate
  always_comb begin
    rsum = {acc[ACC_W-1], acc} + (ACC_W + 1)'(2 ** (wmo_pkg::PROD_SHIFT - 1));
    rq   = rsum >>> wmo_pkg::PROD_SHIFT;
    if (rq > (ACC_W + 1)'(SAT_HI_I)) begin
      sat = SAMPLE_BITS'(SAT_HI_I);
    end else if (rq < (ACC_W + 1)'(SAT_LO_I)) begin
      sat = SAMPLE_BITS'(SAT_LO_I);
    end else begin
      sat = rq[SAMPLE_BITS-1:0];
    end
  end

  assign run_done = (iss == act) && !v_rd && !v_ip && !v_pr && (red_left == '0);

  always_comb begin
    state_next = state;
    case (state)
      wmo_pkg::ST_IDLE: begin
        if (in_acc && (command == wmo_pkg::CMD_SAMPLE)) begin
          state_next = wmo_pkg::ST_RUN;
        end
      end
      wmo_pkg::ST_RUN: begin
        if (run_done) begin
          state_next = wmo_pkg::ST_FIN;
        end
      end
      wmo_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = wmo_pkg::ST_IDLE;
        end
      end
      default: state_next = wmo_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wmo_pkg::ST_IDLE;
      phase     <= '0;
      red_left  <= '0;
      iss       <= '0;
      act       <= '0;
      v_rd      <= 1'b0;
      v_ip      <= 1'b0;
      v_pr      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wmo_pkg::ST_IDLE && in_acc && command == wmo_pkg::CMD_SAMPLE) begin
        // Advance the phase now; the wrap is reduced while the tables are read
        phase    <= phase + SUM_W'(phase_inc);
        red_left <= RL_W'(RED_K + 1);
        iss      <= '0;
        act      <= (tiu_ext > CMP_W'(NUM_TABLES)) ? CNT_W'(NUM_TABLES) : CNT_W'(tables_in_use);
      end
      if (state == wmo_pkg::ST_RUN) begin
        if (red_left != '0) begin
          if (phase >= red_lim) begin
            phase <= phase - red_lim;
          end
          red_left <= red_left - RL_W'(1);
        end
        v_rd <= (iss != act);
        if (iss != act) begin
          iss <= iss + CNT_W'(1);
        end
        v_ip <= v_rd;
        v_pr <= v_ip;
      end
      if (state == wmo_pkg::ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == wmo_pkg::ST_IDLE && in_acc) begin
      below_idx <= cur_below;
      above_idx <= cur_above;
      frac      <= phase[FB-1:0];
      acc       <= '0;
    end
    tbl_rd <= iss[TW-1:0];
    if (v_rd) begin
      interp <= ip_full[IP_W-1:0];
      tbl_ip <= tbl_rd;
    end
    if (v_ip) begin
      prod <= PROD_W'(interp) * PROD_W'(w_sel);
    end
    if (v_pr) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == wmo_pkg::ST_FIN && (!out_valid || out_ready)) begin
      sample_out <= sat;
    end
  end

  `CHK_IMPLY(a_phase_wrapped, state == wmo_pkg::ST_IDLE, phase < SPAN, "phase left unreduced")
  `CHK_IMPLY(a_fin_drained, state == wmo_pkg::ST_FIN, !(v_rd || v_ip || v_pr) && red_left == '0, "early result")
  `CHK_IMPLY(a_pipe_in_run, v_rd || v_ip || v_pr, state == wmo_pkg::ST_RUN, "table pipeline busy outside run")
  `CHK_IMPLY(a_issue_bound, state == wmo_pkg::ST_RUN, iss <= act, "more tables read than active")

endmodule

// ===== dv/wavetable_mix_oscillator_top_tb.sv =====
// Self-checking testbench for the wavetable mix oscillator top level.
module wavetable_mix_oscillator_top_tb;
  import wmo_pkg::*;

  localparam int SAMPLE_W   = 16;
  localparam int NUM_TABS   = 4;
  localparam int TAB_DEPTH  = 256;
  localparam int DRAIN_WAIT = 20;  // comfortably above the run of a sample with four tables
  localparam int RAND_ROUNDS = 8;
  localparam int ROUND_ITEMS = 70;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE = REG_WEIGHT_ZERO + 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW    = REG_WEIGHT_THREE + 3'd1;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef struct {
    logic                       cmd;
    logic [1:0]                 sel;
    logic [7:0]                 idx;
    logic signed [SAMPLE_W-1:0] val;
  } osc_txn_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_WRITE;
  logic [1:0] table_select = '0;
  logic [7:0] entry_index = '0;
  logic signed [SAMPLE_W-1:0] entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;

  wavetable_mix_oscillator_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .table_select(table_select),
    .entry_index(entry_index), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
  );

  always #5 clk = ~clk;

  // Shadow of the oscillator: wave tables, phase accumulator and register file
  logic signed [SAMPLE_W-1:0] wave_store [NUM_TABS][TAB_DEPTH];
  logic [PHASE_INC_W-1:0]     osc_phase = '0;
  logic [PHASE_INC_W-1:0]     phase_step = '0;
  logic [TIU_W-1:0]           tables_cfg = TABLES_RESET;
  logic signed [WEIGHT_W-1:0] mix_weight [NUM_TABS] = '{WEIGHT_ZERO_RESET, 0, 0, 0};

  osc_txn_t                   pending_txns [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  osc_txn_t                   next_txn;

  logic in_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   mismatches = 0;
  int   writes_seen = 0;
  int   samples_checked = 0;
  int   saturated = 0;
  int   reg_writes = 0;

  rx_mode_t    rx_mode = RX_ALWAYS;
  logic [15:0] rx_pattern = 16'hFFFF;
  int          rx_epoch = 0;

  // Work out the next output sample from the shadow state, then advance the phase.
  // The phase wraps on its own at 24 bits, which is exactly the table span.
  function automatic logic signed [SAMPLE_W-1:0] next_mix_sample();
    logic [7:0] idx_lo;
    logic [7:0] idx_hi;
    longint     frac_w;
    longint     blend;
    longint     acc;
    longint     rounded;
    int         active;
    idx_lo  = osc_phase[PHASE_INC_W-1:FRAC_BITS];
    idx_hi  = idx_lo + 8'd1;
    frac_w  = longint'({48'd0, osc_phase[FRAC_BITS-1:0]});
    active  = (tables_cfg > TIU_W'(NUM_TABS)) ? NUM_TABS : int'(tables_cfg);
    acc     = 0;
    for (int t = 0; t < active; t++) begin
      blend = longint'(wave_store[t][idx_lo]) * ((64'sd1 <<< FRAC_BITS) - frac_w)
            + longint'(wave_store[t][idx_hi]) * frac_w;
      acc += blend * longint'(mix_weight[t]);
    end
    osc_phase = osc_phase + phase_step;
    rounded = (acc + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    if (rounded > longint'(S_MAX)) begin
      rounded = longint'(S_MAX);
      saturated++;
    end else if (rounded < longint'(S_MIN)) begin
      rounded = longint'(S_MIN);
      saturated++;
    end
    return SAMPLE_W'(rounded);
  endfunction

  // Register write: one cycle of write enable, mirrored into the shadow at once.
  // Only called with the block idle, so no sample in flight sees the change.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_PHASE_INC)
      phase_step = data[PHASE_INC_W-1:0];
    else if (idx == REG_TABLES)
      tables_cfg = data[TIU_W-1:0];
    else if (idx >= REG_WEIGHT_ZERO && idx <= REG_WEIGHT_THREE)
      mix_weight[idx - REG_WEIGHT_ZERO] = data[WEIGHT_W-1:0];
    reg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_table_write(input logic [1:0] sel, input logic [7:0] idx,
                                   input logic signed [SAMPLE_W-1:0] val);
    osc_txn_t txn;
    txn = '{CMD_WRITE, sel, idx, val};
    pending_txns.push_back(txn);
  endtask

  // Sample request with random filler in the unused fields
  task automatic queue_sample_request();
    osc_txn_t txn;
    txn = '{CMD_SAMPLE, 2'($urandom()), 8'($urandom()), 16'($urandom())};
    pending_txns.push_back(txn);
  endtask

  // Weight with the extremes and unity favoured; upper data bits are don't-care
  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    logic signed [WEIGHT_W-1:0] w;
    case ($urandom_range(0, 5))
      0:       w = S_MAX;
      1:       w = S_MIN;
      2:       w = WEIGHT_ZERO_RESET;
      3:       w = '0;
      default: w = 16'($urandom());
    endcase
    return {8'($urandom()), w};
  endfunction

  // Wait for the queue to empty and every expected sample to arrive, then let
  // a trailing write settle before any register is touched.
  task automatic wait_until_idle();
    while (pending_txns.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Driver: bursts of random length separated by random gaps; hold the payload
  // until the transaction is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold
    end else if (gap_left > 0 || pending_txns.size() == 0) begin
      if (gap_left > 0)
        gap_left--;
      in_valid <= 1'b0;
    end else begin
      next_txn = pending_txns.pop_front();
      in_valid     <= 1'b1;
      command      <= next_txn.cmd;
      table_select <= next_txn.sel;
      entry_index  <= next_txn.idx;
      entry_value  <= next_txn.val;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // Receiver: switch among four stall behaviours, each held for a random epoch
  always @(negedge clk) begin
    if (rx_epoch == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = 16'($urandom());
      rx_epoch   = $urandom_range(20, 80);
    end else begin
      rx_epoch--;
    end
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ready  <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      end
    endcase
  end

  // Monitor: update the shadow on each input transaction, check each output one
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        if (command == CMD_WRITE) begin
          wave_store[table_select][entry_index] = entry_value;
          writes_seen++;
        end else begin
          expected_samples.push_back(next_mix_sample());
        end
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample_out %0d with nothing outstanding", sample_out);
        end else begin
          if (sample_out !== expected_samples[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample %0d: sample_out expected %0d, got %0d",
                       samples_checked, expected_samples[0], sample_out);
          end
          void'(expected_samples.pop_front());
          samples_checked++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every entry first: a read of an unwritten entry is never allowed.
    // Entries 0..3 hold full scale and 4..7 negative full scale for saturation.
    for (int t = 0; t < NUM_TABS; t++)
      for (int i = 0; i < TAB_DEPTH; i++) begin
        if (i < 4)
          queue_table_write(2'(t), 8'(i), S_MAX);
        else if (i < 8)
          queue_table_write(2'(t), 8'(i), S_MIN);
        else if (i == 8)
          queue_table_write(2'(t), 8'(i), '0);
        else
          queue_table_write(2'(t), 8'(i), 16'($urandom()));
      end
    wait_until_idle();

    // Reset settings, phase held at zero: plain copy of table zero
    queue_sample_request();
    queue_sample_request();
    wait_until_idle();

    // All four tables at the largest weight: positive overflow
    write_register(REG_TABLES, 24'd4);
    for (int k = 0; k < NUM_TABS; k++)
      write_register(REG_WEIGHT_ZERO + CFG_IDX_W'(k), {8'hFF, S_MAX});
    queue_sample_request();
    queue_sample_request();
    wait_until_idle();

    // Most negative weights and an oversized table count that clamps to four
    write_register(REG_TABLES, {21'h1FFFFF, 3'd7});
    for (int k = 0; k < NUM_TABS; k++)
      write_register(REG_WEIGHT_ZERO + CFG_IDX_W'(k), {8'h00, S_MIN});
    queue_sample_request();
    queue_sample_request();
    wait_until_idle();

    // No tables mixed: silence; spare register indexes are ignored
    write_register(REG_TABLES, 24'd0);
    write_register(REG_SPARE_LOW, 24'hFFFFFF);
    write_register(REG_SPARE_LOW + 3'd1, 24'hA5A5A5);
    queue_sample_request();
    queue_sample_request();
    wait_until_idle();

    // Largest increment: phase steps backwards by one LSB, wrapping past the
    // table end so entry 255 blends with entry 0
    write_register(REG_PHASE_INC, 24'hFFFFFF);
    write_register(REG_TABLES, 24'd2);
    write_register(REG_WEIGHT_ZERO, {8'h00, WEIGHT_ZERO_RESET});
    write_register(REG_WEIGHT_ZERO + 3'd1, {8'h00, -16'sd8192});
    queue_table_write(2'd3, 8'd255, S_MIN);
    queue_table_write(2'd0, 8'd255, S_MAX);
    queue_table_write(2'd1, 8'd255, '0);
    queue_sample_request();
    queue_sample_request();
    queue_sample_request();
    queue_table_write(2'd2, 8'd0, S_MIN);
    queue_sample_request();
    wait_until_idle();

    // Random rounds: fresh settings each round, then a mix of writes and requests
    for (int r = 0; r < RAND_ROUNDS; r++) begin
      case ($urandom_range(0, 4))
        0:       write_register(REG_PHASE_INC, '0);
        1:       write_register(REG_PHASE_INC, 24'hFFFFFF);
        2:       write_register(REG_PHASE_INC, 24'($urandom_range(0, 24'h3FFFF)));
        default: write_register(REG_PHASE_INC, 24'($urandom()));
      endcase
      write_register(REG_TABLES, {21'($urandom()), 3'($urandom_range(0, 7))});
      for (int k = 0; k < NUM_TABS; k++)
        write_register(REG_WEIGHT_ZERO + CFG_IDX_W'(k), pick_weight());
      if ($urandom_range(0, 1) == 1)
        write_register(REG_SPARE_LOW + CFG_IDX_W'($urandom_range(0, 1)), 24'($urandom()));
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 55)
          queue_sample_request();
        else if ($urandom_range(0, 7) == 0)
          queue_table_write(2'($urandom()), 8'($urandom()),
                            ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN);
        else
          queue_table_write(2'($urandom()), 8'($urandom()), 16'($urandom()));
      end
      wait_until_idle();
    end

    if (expected_samples.size() != 0)
      mismatches += expected_samples.size();
    $display("covered %0d table writes and %0d checked samples (%0d saturated)",
             writes_seen, samples_checked, saturated);
    $display("across %0d register writes and %0d random rounds, %0d mismatches",
             reg_writes, RAND_ROUNDS, mismatches);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== wavetable_mix_oscillator_top.f =====
+incdir+hw/rtl
hw/rtl/wmo_pkg.sv
hw/rtl/wmo_ram.sv
hw/rtl/wavetable_mix_oscillator_top.sv
dv/wavetable_mix_oscillator_top_tb.sv
